// ===== rtl/core/ksdp_pkg.sv =====
// Shared constants for the 0/1 knapsack solver: table geometry and field widths.
// No dependencies.
package ksdp_pkg;

    localparam int MAX_ITEMS    = 32;
    localparam int ITEM_W       = 5;
    localparam int CNT_W        = 6;
    localparam int CAP_W        = 10;
    localparam int TABLE_DEPTH  = 1024;
    localparam int VAL_W        = 16;
    localparam int TOT_W        = 21;
    localparam int ROW_W        = TOT_W + MAX_ITEMS;

    localparam logic [CAP_W-1:0] MAX_CAPACITY = 10'd1023;
    localparam logic [CNT_W-1:0] ITEM_LIMIT   = 6'd32;
    localparam logic [TOT_W-1:0] TOTAL_MAX    = {TOT_W{1'b1}};

    localparam logic KIND_TOTAL = 1'b0;
    localparam logic KIND_INDEX = 1'b1;
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_SOLVE  = 1'b1;

endpackage

// ===== rtl/core/ksdp_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module ksdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/core/knapsack_01_dp_solver.sv =====
// 0/1 knapsack solver top level: request control, table update pipeline, trace and output.
// Depends on ksdp_pkg and ksdp_ram.
//
// Each table row holds the best total for one capacity and one choice bit per item,
// in a single 1024-row RAM. After reset and after every solve the block clears all
// 1024 rows, one per cycle, with busy high. During an add one row is read, updated
// and written back per cycle, highest capacity first, so a write never lands on a
// row still to be read. An add that is dropped or whose weight exceeds the capacity
// leaves busy low. A solve reads the best total, traces the choice bits from the last
// added item down to the first, emits the total, then scans the items in ascending
// order at one cycle each and strobes every chosen index, then starts the clear.
// Results cannot be held off: capture each one while o_result_valid is high.
module knapsack_01_dp_solver
    import ksdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [CAP_W-1:0]  i_item_weight,
    input  logic [VAL_W-1:0]  i_item_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output logic              o_result_valid,
    output logic              o_result_kind,
    output logic [TOT_W-1:0]  o_total_value,
    output logic [ITEM_W-1:0] o_item_index,
    output logic              o_overflow,
    output logic              o_last
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_TOT    = 3'd4;
    localparam logic [2:0] S_TRD    = 3'd5;
    localparam logic [2:0] S_TCK    = 3'd6;
    localparam logic [2:0] S_EMIT_T = 3'd7;

    logic [2:0]           r_state, n_state;
    logic                 r_emit_i, n_emit_i;
    logic [CAP_W-1:0]     r_cap;
    logic [CAP_W-1:0]     r_w, n_w;
    logic [CAP_W-1:0]     r_w1;
    logic                 r_p1;
    logic [CAP_W-1:0]     r_wt, n_wt;
    logic [VAL_W-1:0]     r_val, n_val;
    logic [ITEM_W-1:0]    r_idx, n_idx;
    logic [ITEM_W-1:0]    r_i, n_i;
    logic [ITEM_W-1:0]    r_j, n_j;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic [MAX_ITEMS-1:0] r_mask, n_mask;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [CAP_W-1:0]     r_weights [MAX_ITEMS];

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [TOT_W-1:0]     r_out_total, n_out_total;
    logic [ITEM_W-1:0]    r_out_index, n_out_index;
    logic                 r_out_ovf, n_out_ovf;
    logic                 r_out_last, n_out_last;

    logic                 accept;
    logic [CAP_W-1:0]     cap_eff;
    logic                 we;
    logic [CAP_W-1:0]     waddr;
    logic [ROW_W-1:0]     wdata;
    logic [CAP_W-1:0]     raddr_a, raddr_b;
    logic [ROW_W-1:0]     rd_a, rd_b;
    logic [TOT_W:0]       cand_sum;
    logic [TOT_W-1:0]     cand;
    logic                 better;
    logic [MAX_ITEMS-1:0] idx_bit;
    logic [CAP_W-1:0]     trace_wt;
    logic                 wr_weight;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cap_eff     = (r_cap < MAX_CAPACITY) ? r_cap : MAX_CAPACITY;

    assign cand_sum = {{(TOT_W + 1 - VAL_W){1'b0}}, r_val} + {1'b0, rd_b[TOT_W-1:0]};
    assign cand     = cand_sum[TOT_W] ? TOTAL_MAX : cand_sum[TOT_W-1:0];
    assign better   = cand > rd_a[TOT_W-1:0];
    assign idx_bit  = {{(MAX_ITEMS-1){1'b0}}, 1'b1} << r_idx;
    assign trace_wt = r_weights[r_i];

    always_comb begin
        raddr_a = r_w;
        raddr_b = r_w - r_wt;
        if (r_state == S_IDLE) begin
            raddr_a = cap_eff;
        end
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_w;
            wdata = '0;
        end else begin
            we    = r_p1 && better;
            waddr = r_w1;
            wdata = {rd_a[ROW_W-1:TOT_W] | idx_bit, cand};
        end
    end

    ksdp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        n_state     = r_state;
        n_emit_i    = 1'b0;
        n_w         = r_w;
        n_wt        = r_wt;
        n_val       = r_val;
        n_idx       = r_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_mask      = r_mask;
        n_total     = r_total;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_total = r_out_total;
        n_out_index = r_out_index;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        wr_weight   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_w = r_w + 1'b1;
                if (r_w == MAX_CAPACITY) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_SOLVE) begin
                        n_w     = cap_eff;
                        n_mask  = '0;
                        n_state = S_TOT;
                    end else if (r_cnt == ITEM_LIMIT) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_weight = 1'b1;
                        n_cnt     = r_cnt + 1'b1;
                        n_idx     = r_cnt[ITEM_W-1:0];
                        n_wt      = i_item_weight;
                        n_val     = i_item_value;
                        n_w       = cap_eff;
                        if (i_item_weight <= cap_eff) begin
                            n_state = S_ADD;
                        end
                    end
                end
            end
            S_ADD: begin
                if (r_w == r_wt) begin
                    n_state = S_DRAIN;
                end else begin
                    n_w = r_w - 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_TOT: begin
                n_total = rd_a[TOT_W-1:0];
                if (r_cnt == '0) begin
                    n_state = S_EMIT_T;
                end else begin
                    n_i     = ITEM_W'(r_cnt - 1'b1);
                    n_state = S_TCK;
                end
            end
            S_TRD: begin
                n_state = S_TCK;
            end
            S_TCK: begin
                if (rd_a[TOT_W + 32'(r_i)]) begin
                    n_mask[r_i] = 1'b1;
                    n_w = (r_w >= trace_wt) ? r_w - trace_wt : '0;
                end
                if (r_i == '0) begin
                    n_state = S_EMIT_T;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_state = S_TRD;
                end
            end
            S_EMIT_T: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_TOTAL;
                n_out_total = r_total;
                n_out_index = '0;
                n_out_ovf   = r_ovf;
                n_out_last  = (r_mask == '0);
                n_j         = '0;
                if (r_mask == '0) begin
                    n_state = S_CLEAR;
                    n_w     = '0;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_emit_i = 1'b1;
                    n_state  = S_TRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_emit_i) begin
            n_state  = S_TRD;
            n_emit_i = 1'b1;
            n_j      = r_j + 1'b1;
            if (r_mask[r_j]) begin
                n_mask[r_j] = 1'b0;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_INDEX;
                n_out_total = '0;
                n_out_index = r_j;
                n_out_ovf   = r_ovf;
                n_out_last  = (n_mask == '0);
                if (n_mask == '0) begin
                    n_emit_i = 1'b0;
                    n_state  = S_CLEAR;
                    n_w      = '0;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_emit_i    <= 1'b0;
            r_cap       <= '0;
            r_w         <= '0;
            r_p1        <= 1'b0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit_i    <= n_emit_i;
            r_w         <= n_w;
            r_p1        <= (r_state == S_ADD);
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1        <= r_w;
        r_wt        <= n_wt;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_i         <= n_i;
        r_j         <= n_j;
        r_mask      <= n_mask;
        r_total     <= n_total;
        r_out_kind  <= n_out_kind;
        r_out_total <= n_out_total;
        r_out_index <= n_out_index;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
        if (wr_weight) begin
            r_weights[r_cnt[ITEM_W-1:0]] <= i_item_weight;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_total_value  = r_out_total;
    assign o_item_index   = r_out_index;
    assign o_overflow     = r_out_ovf;
    assign o_last         = r_out_last;

endmodule
